// ===== rtl/core/wwd_pkg.sv =====
// ----------------------------------------------------------------------------
// wwd_pkg
// Shared constants and controller/datapath interface types for the wildcard
// word dictionary.
// ----------------------------------------------------------------------------
`default_nettype none

package wwd_pkg;

  localparam int MAX_WORD_LEN_DEF = 32;
  localparam int TABLE_DEPTH_DEF  = 64;

  localparam logic [7:0] WILDCARD_CHAR = 8'd46;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_FULL = 2'd1;
  localparam logic [1:0] STATUS_LONG = 2'd2;

  typedef struct packed {
    logic       take_char;
    logic       clear_word;
    logic       commit_add;
    logic       search_start;
    logic       issue;
    logic       load_out;
    logic       out_kind;
    logic       out_use_found;
    logic [1:0] out_status;
  } cmd_t;

  typedef struct packed {
    logic overflow_now;
    logic table_full;
    logic ptr_done;
    logic pend;
    logic found;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/wwd_ctrl.sv =====
// ----------------------------------------------------------------------------
// wwd_ctrl
// Controller: sequences character intake, word-end handling and the search
// walk over stored entries.
// ----------------------------------------------------------------------------
`default_nettype none

module wwd_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire logic           in_operation_i,
  input  wire logic           in_last_char_i,
  input  wire wwd_pkg::stat_t stat_i,
  output wwd_pkg::cmd_t       cmd_o
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SRCH = 1'b1;

  logic state_q, state_d;
  logic accept;

  assign in_stall_o = (state_q != S_IDLE) || stat_i.out_busy;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.take_char = 1'b1;
          if (in_last_char_i) begin
            if (stat_i.overflow_now) begin
              cmd_o.clear_word = 1'b1;
              cmd_o.load_out   = 1'b1;
              cmd_o.out_kind   = in_operation_i;
              cmd_o.out_status = wwd_pkg::STATUS_LONG;
            end else if (in_operation_i == wwd_pkg::OP_ADD) begin
              cmd_o.clear_word = 1'b1;
              cmd_o.load_out   = 1'b1;
              cmd_o.out_kind   = wwd_pkg::KIND_ADD;
              if (stat_i.table_full) begin
                cmd_o.out_status = wwd_pkg::STATUS_FULL;
              end else begin
                cmd_o.commit_add = 1'b1;
                cmd_o.out_status = wwd_pkg::STATUS_OK;
              end
            end else begin
              cmd_o.search_start = 1'b1;
              state_d            = S_SRCH;
            end
          end
        end
      end
      S_SRCH: begin
        cmd_o.issue = !stat_i.ptr_done && !stat_i.found;
        if ((stat_i.ptr_done || stat_i.found) && !stat_i.pend && !stat_i.out_busy) begin
          cmd_o.load_out      = 1'b1;
          cmd_o.out_kind      = wwd_pkg::KIND_SEARCH;
          cmd_o.out_use_found = 1'b1;
          cmd_o.out_status    = wwd_pkg::STATUS_OK;
          cmd_o.clear_word    = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_accept_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH) |-> !cmd_o.take_char)
    else $error("character taken during search walk");

  a_search_ends_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH && cmd_o.load_out) |=> (state_q == S_IDLE))
    else $error("search result loaded without returning to idle");

  a_search_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($rose(state_q == S_SRCH)) |-> $past(cmd_o.search_start))
    else $error("search walk entered without start");

endmodule

`default_nettype wire

// ===== rtl/core/wwd_datapath.sv =====
// ----------------------------------------------------------------------------
// wwd_datapath
// Datapath: word buffer, entry table (row memory and length memory), search
// pointer with registered row compare, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wwd_datapath #(
  parameter int MAX_WORD_LEN = wwd_pkg::MAX_WORD_LEN_DEF,
  parameter int TABLE_DEPTH  = wwd_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [7:0]    in_char_code_i,
  input  wire wwd_pkg::cmd_t cmd_i,
  output wwd_pkg::stat_t     stat_o,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic               out_result_kind_o,
  output logic               out_found_o,
  output logic [1:0]         out_status_o
);

  localparam int LW = $clog2(MAX_WORD_LEN + 1);
  localparam int PW = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int EW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef logic [MAX_WORD_LEN-1:0][7:0] row_t;

  row_t            row_mem [TABLE_DEPTH];
  logic [LW-1:0]   len_mem [TABLE_DEPTH];
  logic [7:0]      buf_q   [MAX_WORD_LEN];

  logic [LW-1:0]   len_q;
  logic            ovf_q;
  logic [CW-1:0]   count_q;
  logic [CW-1:0]   ptr_q;
  logic            pend_q;
  logic            found_q;
  row_t            row_q;
  logic [LW-1:0]   rlen_q;

  logic            room;
  logic            full;
  logic [PW-1:0]   lane;
  logic [LW-1:0]   len_inc;
  logic            match;
  logic [MAX_WORD_LEN-1:0] pos_ok;

  assign room    = (len_q < LW'(MAX_WORD_LEN));
  assign full    = (count_q == CW'(TABLE_DEPTH));
  assign lane    = len_q[PW-1:0];
  assign len_inc = len_q + LW'(1);

  assign stat_o.overflow_now = ovf_q || !room;
  assign stat_o.table_full   = full;
  assign stat_o.ptr_done     = (ptr_q == count_q);
  assign stat_o.pend         = pend_q;
  assign stat_o.found        = found_q;
  assign stat_o.out_busy     = out_valid_o && out_stall_i;

  // Characters go to the buffer and straight into the next free row.
  always_ff @(posedge clk_i) begin
    if (cmd_i.take_char && room) begin
      buf_q[lane] <= in_char_code_i;
      if (!full) begin
        row_mem[count_q[EW-1:0]][lane] <= in_char_code_i;
      end
    end
    if (cmd_i.commit_add) begin
      len_mem[count_q[EW-1:0]] <= len_inc;
    end
    if (cmd_i.issue) begin
      row_q  <= row_mem[ptr_q[EW-1:0]];
      rlen_q <= len_mem[ptr_q[EW-1:0]];
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_WORD_LEN; i++) begin
      pos_ok[i] = (LW'(i) >= len_q) || (buf_q[i] == wwd_pkg::WILDCARD_CHAR) ||
                  (buf_q[i] == row_q[i]);
    end
    match = (rlen_q == len_q) && (&pos_ok);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      ovf_q   <= 1'b0;
      count_q <= '0;
      ptr_q   <= '0;
      pend_q  <= 1'b0;
      found_q <= 1'b0;
    end else begin
      if (cmd_i.clear_word) begin
        len_q <= '0;
        ovf_q <= 1'b0;
      end else if (cmd_i.take_char) begin
        if (room) begin
          len_q <= len_inc;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.commit_add) begin
        count_q <= count_q + CW'(1);
      end
      pend_q <= cmd_i.issue;
      if (cmd_i.search_start) begin
        ptr_q   <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.issue) begin
          ptr_q <= ptr_q + CW'(1);
        end
        if (pend_q && match) begin
          found_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_result_kind_o <= cmd_i.out_kind;
      out_found_o       <= cmd_i.out_use_found && found_q;
      out_status_o      <= cmd_i.out_status;
    end
  end

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> !(out_valid_o && out_stall_i))
    else $error("result register overwritten while stalled");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_issue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> (ptr_q < count_q))
    else $error("read issued past last stored entry");

endmodule

`default_nettype wire

// ===== rtl/core/wildcard_word_dictionary_top.sv =====
// ----------------------------------------------------------------------------
// wildcard_word_dictionary_top
// Word dictionary with '.' wildcard search. Words arrive one character per
// item; an add stores the word while the table has room, a search reports
// whether a stored word of equal length matches; an over-long word gets LONG.
//
//   Channel | Direction | Handshake           | Payload
//   --------+-----------+---------------------+------------------------------
//   in      | input     | in_valid_i/in_stall_o   | operation, char_code, last_char
//   out     | output    | out_valid_o/out_stall_i | result_kind, found, status
//
// An add or dropped word has its result loaded when its last character is accepted.
// A search word end holds the input until its walk ends: the walk reads one
// table row per cycle and stops early on a hit.
// Reset clears counts and control; table contents stay undefined.
// Input stalls during a search walk and while a result waits on a stall.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_word_dictionary_top #(
  parameter int MAX_WORD_LEN = wwd_pkg::MAX_WORD_LEN_DEF,
  parameter int TABLE_DEPTH  = wwd_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic       in_operation_i,
  input  wire logic [7:0] in_char_code_i,
  input  wire logic       in_last_char_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            out_result_kind_o,
  output logic            out_found_o,
  output logic [1:0]      out_status_o
);

  wwd_pkg::cmd_t  cmd;
  wwd_pkg::stat_t stat;

  wwd_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .in_operation_i (in_operation_i),
    .in_last_char_i (in_last_char_i),
    .stat_i         (stat),
    .cmd_o          (cmd)
  );

  wwd_datapath #(
    .MAX_WORD_LEN (MAX_WORD_LEN),
    .TABLE_DEPTH  (TABLE_DEPTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_char_code_i    (in_char_code_i),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .out_result_kind_o (out_result_kind_o),
    .out_found_o       (out_found_o),
    .out_status_o      (out_status_o)
  );

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wildcard word dictionary. Words go in one
// character per item and a scoreboard predicts the add or search answer
// due at each word end. Directed words come first, then random words; some
// searches are built from stored entries with '.' inserted. Both sides idle
// at random, and once the result side holds off for a long stretch.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_LEN   = wwd_pkg::MAX_WORD_LEN_DEF;
  localparam int DEPTH     = wwd_pkg::TABLE_DEPTH_DEF;
  localparam int RAND_ITEMS = 850;

  typedef struct packed {
    logic       kind;
    logic       found;
    logic [1:0] status;
  } answer_t;

  class dict_scoreboard;
    logic [7:0] entry_chars [DEPTH][MAX_LEN];
    int         entry_len [DEPTH];
    int         entry_count;
    logic [7:0] word_chars [MAX_LEN];
    int         cur_len;
    bit         overflow;
    answer_t    pending [$];
    int         errors;

    function void note_item(logic op, logic [7:0] ch, logic last);
      answer_t a;
      bit      hit;
      bit      same;
      if (cur_len < MAX_LEN) begin
        word_chars[cur_len] = ch;
        cur_len++;
      end else begin
        overflow = 1;
      end
      if (!last) return;
      a.kind   = op;
      a.found  = 1'b0;
      a.status = wwd_pkg::STATUS_OK;
      hit      = 0;
      if (overflow) begin
        a.status = wwd_pkg::STATUS_LONG;
      end else if (op == wwd_pkg::OP_ADD) begin
        if (entry_count >= DEPTH) begin
          a.status = wwd_pkg::STATUS_FULL;
        end else begin
          for (int i = 0; i < cur_len; i++) entry_chars[entry_count][i] = word_chars[i];
          entry_len[entry_count] = cur_len;
          entry_count++;
        end
      end else begin
        for (int e = 0; e < entry_count; e++) begin
          same = (entry_len[e] == cur_len);
          for (int i = 0; i < cur_len && same; i++)
            if (word_chars[i] != wwd_pkg::WILDCARD_CHAR &&
                word_chars[i] != entry_chars[e][i]) same = 0;
          if (same) hit = 1;
        end
        a.found = hit;
      end
      pending = {pending, a};
      cur_len  = 0;
      overflow = 0;
    endfunction

    function void check_answer(logic kind, logic found, logic [1:0] status);
      answer_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result kind %0d found %0d status %0d",
                 $time, kind, found, status);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (want.kind !== kind) begin
        $display("%0t: result_kind expected %0d actual %0d", $time, want.kind, kind);
        errors++;
      end
      if (want.found !== found) begin
        $display("%0t: found expected %0d actual %0d", $time, want.found, found);
        errors++;
      end
      if (want.status !== status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        errors++;
      end
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic       in_operation_i = 1'b0;
  logic [7:0] in_char_code_i = 8'd0;
  logic       in_last_char_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic       out_result_kind_o;
  logic       out_found_o;
  logic [1:0] out_status_o;

  dict_scoreboard sb = new();

  int         send_idle_pct = 26;
  int         recv_idle_pct = 66;
  int         items_sent;
  int         answers_seen;
  int         hold_left;
  bit         hold_done;
  logic [7:0] stim_chars [40];
  int         stim_len;

  wildcard_word_dictionary_top dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_operation_i   (in_operation_i),
    .in_char_code_i   (in_char_code_i),
    .in_last_char_i   (in_last_char_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_result_kind_o(out_result_kind_o),
    .out_found_o      (out_found_o),
    .out_status_o     (out_status_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("tb: errors");
    $finish;
  end

  // result monitor and stall generator; one long hold-off backs up the input
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_answer(out_result_kind_o, out_found_o, out_status_o);
      answers_seen++;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && answers_seen >= 40) begin
      hold_done   <= 1'b1;
      hold_left   <= 300;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic send_item(input logic op, input logic [7:0] ch, input logic last);
    if (items_sent >= 580) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end else if (items_sent >= 290) begin
      send_idle_pct = 66;
      recv_idle_pct = 26;
    end
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    in_operation_i <= op;
    in_char_code_i <= ch;
    in_last_char_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(op, ch, last);
    items_sent++;
  endtask

  // only the final item's operation counts; earlier ones are random
  task automatic send_word(input logic op);
    logic item_op;
    for (int i = 0; i < stim_len; i++) begin
      item_op = (i == stim_len - 1) ? op : logic'($urandom_range(1));
      send_item(item_op, stim_chars[i], i == stim_len - 1);
    end
  endtask

  task automatic send_text(input logic op, input string s);
    for (int i = 0; i < s.len(); i++) stim_chars[i] = s[i];
    stim_len = s.len();
    send_word(op);
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 60) return (r < 30) ? "a" : "b";
    if (r < 70) return wwd_pkg::WILDCARD_CHAR;
    return 8'($urandom_range(255));
  endfunction

  task automatic random_word();
    int   r;
    int   e;
    int   len;
    logic op;
    r = $urandom_range(99);
    if (r < 4) len = $urandom_range(35, 33);
    else if (r < 8) len = MAX_LEN;
    else if (r < 14) len = $urandom_range(31, 5);
    else len = $urandom_range(4, 1);
    op = ($urandom_range(99) < 40) ? wwd_pkg::OP_ADD : wwd_pkg::OP_SEARCH;
    for (int i = 0; i < len; i++) stim_chars[i] = pick_char();
    if (op == wwd_pkg::OP_SEARCH && sb.entry_count > 0 && $urandom_range(99) < 70) begin
      e   = $urandom_range(sb.entry_count - 1);
      len = sb.entry_len[e];
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(99);
        if (r < 20) stim_chars[i] = wwd_pkg::WILDCARD_CHAR;
        else if (r < 28) stim_chars[i] = pick_char();
        else stim_chars[i] = sb.entry_chars[e][i];
      end
    end
    stim_len = len;
    send_word(op);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text(wwd_pkg::OP_SEARCH, "a");
    stim_chars[0] = 8'h00;
    stim_chars[1] = 8'hFF;
    stim_len = 2;
    send_word(wwd_pkg::OP_ADD);
    send_text(wwd_pkg::OP_ADD, "a.b");
    send_text(wwd_pkg::OP_SEARCH, "a.b");
    send_text(wwd_pkg::OP_SEARCH, "...");
    send_text(wwd_pkg::OP_SEARCH, "ab");
    send_text(wwd_pkg::OP_SEARCH, "x.b");
    stim_chars[0] = 8'h00;
    stim_chars[1] = wwd_pkg::WILDCARD_CHAR;
    stim_len = 2;
    send_word(wwd_pkg::OP_SEARCH);
    send_text(wwd_pkg::OP_SEARCH, ".");
    send_text(wwd_pkg::OP_ADD, "z");
    send_text(wwd_pkg::OP_SEARCH, ".");
    stim_chars[0] = 8'hFF;
    stim_chars[1] = 8'h00;
    stim_len = 2;
    send_word(wwd_pkg::OP_SEARCH);

    while (items_sent < RAND_ITEMS + 24) random_word();
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DEPTH + 8) @(posedge clk_i);
    if (sb.pending.size() != 0)
      $display("%0t: %0d answers never arrived", $time, sb.pending.size());
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
rtl/core/wwd_pkg.sv
rtl/core/wwd_ctrl.sv
rtl/core/wwd_datapath.sv
rtl/core/wildcard_word_dictionary_top.sv
verif/tb.sv
